FILE: design/rgbpw_pkg.sv
package rgbpw_pkg;

    // Width of a measured pulse and of the calibration registers.
    localparam int unsigned WIDTH_BITS = 16;
    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned THR_W      = 8;
    localparam int unsigned NUM_CHAN   = 3;

    // 255 * |raw - low| needs LEVEL_W more bits than the magnitude itself.
    localparam int unsigned NUM_W = WIDTH_BITS + LEVEL_W;

    // Input register, scaling stage, one stage per quotient bit, level stage.
    localparam int unsigned NUM_STAGES = LEVEL_W + 3;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_RED_LOW    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RED_HIGH   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_LOW  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_HIGH = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_LOW   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_HIGH  = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = CFG_IDX_W'(6);

    localparam logic [WIDTH_BITS-1:0] RST_WIDTH_LOW  = WIDTH_BITS'(0);
    localparam logic [WIDTH_BITS-1:0] RST_WIDTH_HIGH = WIDTH_BITS'(1000);
    localparam logic [THR_W-1:0]      RST_THRESHOLD  = THR_W'(50);

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

    typedef enum logic [1:0] {
        CLASS_NONE  = 2'd0,
        CLASS_RED   = 2'd1,
        CLASS_GREEN = 2'd2,
        CLASS_BLUE  = 2'd3
    } color_class_t;

    // Per-channel pipeline payload. When fixed is set, lvl already holds the
    // final level; otherwise lvl collects quotient bits.
    typedef struct packed {
        logic                  fixed;
        logic [LEVEL_W-1:0]    lvl;
        logic [NUM_W-1:0]      rem;
        logic [WIDTH_BITS-1:0] den;
    } chan_t;

    typedef struct packed {
        chan_t [NUM_CHAN-1:0] ch;
        logic                 err;
    } stage_t;

endpackage

FILE: design/rgb_pulse_width_color_classifier.sv
// Color classifier for three filtered pulse-width measurements.
// Input channel (s_valid/s_ready): one beat carries the red, green and blue
// low-pulse widths. Result channel (m_valid/m_ready): one beat carries the
// three levels (0..255), the dominant color class and a flag that is set when
// any channel's calibration pair has zero span.
// Configuration channel (cfg_valid/cfg_ready): cfg_index selects a register
// (0/1 red low/high, 2/3 green low/high, 4/5 blue low/high, 6 threshold) and
// cfg_data is written into it; other indexes are ignored. cfg_ready is always
// high. Change registers only while no beat is in flight; it is not enforced.
//
// The block takes one beat per cycle unless the result channel stalls. The
// depth is set by the division: one restoring quotient bit is resolved per
// stage, eight stages in all, behind an input stage and a scaling stage,
// followed by the level stage and the classifier in front of the output
// register.
//
// Reset clears every stage valid bit and the output valid, and loads the
// calibration defaults. When the receiver stalls, each stage holds its beat
// while bubbles ahead of it still close up, so s_ready falls only once every
// stage is full.
module rgb_pulse_width_color_classifier (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rgbpw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rgbpw_pkg::WIDTH_BITS-1:0]     cfg_data,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [rgbpw_pkg::WIDTH_BITS-1:0]     s_red_width,
    input  logic [rgbpw_pkg::WIDTH_BITS-1:0]     s_green_width,
    input  logic [rgbpw_pkg::WIDTH_BITS-1:0]     s_blue_width,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [rgbpw_pkg::LEVEL_W-1:0]        m_red_level,
    output logic [rgbpw_pkg::LEVEL_W-1:0]        m_green_level,
    output logic [rgbpw_pkg::LEVEL_W-1:0]        m_blue_level,
    output logic [1:0]                           m_color_class,
    output logic                                 m_range_error
);

    localparam int unsigned NS = rgbpw_pkg::NUM_STAGES;
    localparam int unsigned LW = rgbpw_pkg::LEVEL_W;
    localparam int unsigned NW = rgbpw_pkg::NUM_W;
    localparam int unsigned WB = rgbpw_pkg::WIDTH_BITS;
    localparam int unsigned BIT_IDX_W = $clog2(LW);

    // One pipeline step. Stage 1 scales the magnitude by 255, stage 2 also
    // checks whether the quotient would reach 256 (level clamps to 0), stages
    // 2 to LW+1 each resolve one quotient bit, and the last stage turns the
    // quotient Q into the level 255 - Q.
    function automatic rgbpw_pkg::stage_t step_stage(rgbpw_pkg::stage_t prev,
                                                     int unsigned k);
        rgbpw_pkg::stage_t nxt;
        logic [NW-1:0]     dsh;
        int unsigned       bitpos;
        nxt = prev;
        for (int c = 0; c < int'(rgbpw_pkg::NUM_CHAN); c++) begin
            if (k == 1) begin
                nxt.ch[c].rem = (prev.ch[c].rem << LW) - prev.ch[c].rem;
            end else if (k <= LW + 1) begin
                bitpos = LW + 1 - k;
                dsh    = NW'(prev.ch[c].den) << bitpos;
                if (k == 2 && !prev.ch[c].fixed
                        && prev.ch[c].rem >= {prev.ch[c].den, LW'(0)}) begin
                    nxt.ch[c].fixed = 1'b1;
                    nxt.ch[c].lvl   = '0;
                end else if (!prev.ch[c].fixed && prev.ch[c].rem >= dsh) begin
                    nxt.ch[c].rem = prev.ch[c].rem - dsh;
                    nxt.ch[c].lvl[bitpos[BIT_IDX_W-1:0]] = 1'b1;
                end
            end else begin
                if (!prev.ch[c].fixed) begin
                    nxt.ch[c].lvl = ~prev.ch[c].lvl;
                end
            end
        end
        return nxt;
    endfunction

    // Configuration registers.
    logic [WB-1:0]                  width_low_reg  [rgbpw_pkg::NUM_CHAN];
    logic [WB-1:0]                  width_high_reg [rgbpw_pkg::NUM_CHAN];
    logic [rgbpw_pkg::THR_W-1:0]    thr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < int'(rgbpw_pkg::NUM_CHAN); c++) begin
                width_low_reg[c]  <= rgbpw_pkg::RST_WIDTH_LOW;
                width_high_reg[c] <= rgbpw_pkg::RST_WIDTH_HIGH;
            end
            thr_reg <= rgbpw_pkg::RST_THRESHOLD;
        end else if (cfg_valid) begin
            case (cfg_index)
                rgbpw_pkg::CFG_RED_LOW:    width_low_reg[0]  <= cfg_data;
                rgbpw_pkg::CFG_RED_HIGH:   width_high_reg[0] <= cfg_data;
                rgbpw_pkg::CFG_GREEN_LOW:  width_low_reg[1]  <= cfg_data;
                rgbpw_pkg::CFG_GREEN_HIGH: width_high_reg[1] <= cfg_data;
                rgbpw_pkg::CFG_BLUE_LOW:   width_low_reg[2]  <= cfg_data;
                rgbpw_pkg::CFG_BLUE_HIGH:  width_high_reg[2] <= cfg_data;
                rgbpw_pkg::CFG_THRESHOLD:  thr_reg <= cfg_data[rgbpw_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline registers and flow control.
    rgbpw_pkg::stage_t stage_reg  [NS];
    rgbpw_pkg::stage_t stage_next [NS];
    logic [NS-1:0]     vld_reg;
    logic [NS-1:0]     vld_next;
    logic [NS:0]       rdy;

    logic [WB-1:0]     raw [rgbpw_pkg::NUM_CHAN];

    assign raw[0] = s_red_width;
    assign raw[1] = s_green_width;
    assign raw[2] = s_blue_width;

    // A stage may load when it is empty or its beat moves on this cycle.
    always_comb begin
        rdy[NS] = !m_valid || m_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_ready = rdy[0];

    // Input stage: form |raw - low| and |high - low| and settle the cases
    // that need no division. When raw - low and high - low differ in sign,
    // or raw equals low, the quotient is not positive and the level is 255.
    always_comb begin
        logic raw_ge, span_ge, zero_span, zero_diff;
        stage_next[0] = '0;
        for (int c = 0; c < int'(rgbpw_pkg::NUM_CHAN); c++) begin
            raw_ge    = raw[c] >= width_low_reg[c];
            span_ge   = width_high_reg[c] >= width_low_reg[c];
            zero_span = width_high_reg[c] == width_low_reg[c];
            zero_diff = raw[c] == width_low_reg[c];
            stage_next[0].ch[c].rem = NW'(raw_ge ? raw[c] - width_low_reg[c]
                                                 : width_low_reg[c] - raw[c]);
            stage_next[0].ch[c].den = span_ge ? width_high_reg[c] - width_low_reg[c]
                                              : width_low_reg[c] - width_high_reg[c];
            if (zero_span) begin
                stage_next[0].ch[c].fixed = 1'b1;
                stage_next[0].ch[c].lvl   = '0;
                stage_next[0].err         = 1'b1;
            end else if (zero_diff || (raw_ge != span_ge)) begin
                stage_next[0].ch[c].fixed = 1'b1;
                stage_next[0].ch[c].lvl   = rgbpw_pkg::LEVEL_MAX;
            end
        end
        for (int k = 1; k < int'(NS); k++) begin
            stage_next[k] = step_stage(stage_reg[k-1], k);
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (rdy[0]) begin
            vld_next[0] = s_valid;
        end
        for (int k = 1; k < int'(NS); k++) begin
            if (rdy[k]) begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < int'(NS); k++) begin
            if (rdy[k]) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    // Classifier on the final levels.
    logic [LW-1:0]             lvl_r, lvl_g, lvl_b;
    logic [LW:0]               r_plus_t, g_plus_t, b_plus_t;
    rgbpw_pkg::color_class_t   class_next;

    assign lvl_r = stage_reg[NS-1].ch[0].lvl;
    assign lvl_g = stage_reg[NS-1].ch[1].lvl;
    assign lvl_b = stage_reg[NS-1].ch[2].lvl;

    assign r_plus_t = {1'b0, lvl_r} + {1'b0, thr_reg};
    assign g_plus_t = {1'b0, lvl_g} + {1'b0, thr_reg};
    assign b_plus_t = {1'b0, lvl_b} + {1'b0, thr_reg};

    always_comb begin
        if (lvl_r < thr_reg && lvl_g < thr_reg && lvl_b < thr_reg) begin
            class_next = rgbpw_pkg::CLASS_NONE;
        end else if ({1'b0, lvl_r} > g_plus_t && {1'b0, lvl_r} > b_plus_t) begin
            class_next = rgbpw_pkg::CLASS_RED;
        end else if ({1'b0, lvl_g} > r_plus_t && {1'b0, lvl_g} > b_plus_t) begin
            class_next = rgbpw_pkg::CLASS_GREEN;
        end else if ({1'b0, lvl_b} > r_plus_t && {1'b0, lvl_b} > g_plus_t) begin
            class_next = rgbpw_pkg::CLASS_BLUE;
        end else begin
            class_next = rgbpw_pkg::CLASS_NONE;
        end
    end

    // Output register.
    logic                    m_valid_reg;
    logic [LW-1:0]           red_level_reg, green_level_reg, blue_level_reg;
    logic [1:0]              color_class_reg;
    logic                    range_error_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rdy[NS]) begin
            m_valid_reg <= vld_reg[NS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[NS] && vld_reg[NS-1]) begin
            red_level_reg   <= lvl_r;
            green_level_reg <= lvl_g;
            blue_level_reg  <= lvl_b;
            color_class_reg <= class_next;
            range_error_reg <= stage_reg[NS-1].err;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_red_level   = red_level_reg;
    assign m_green_level = green_level_reg;
    assign m_blue_level  = blue_level_reg;
    assign m_color_class = color_class_reg;
    assign m_range_error = range_error_reg;

endmodule

FILE: sim/rgbpw_checker.sv
module rgbpw_checker (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [rgbpw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgbpw_pkg::WIDTH_BITS-1:0] cfg_data,

    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [rgbpw_pkg::WIDTH_BITS-1:0] s_red_width,
    input  logic [rgbpw_pkg::WIDTH_BITS-1:0] s_green_width,
    input  logic [rgbpw_pkg::WIDTH_BITS-1:0] s_blue_width,

    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [rgbpw_pkg::LEVEL_W-1:0]    m_red_level,
    input  logic [rgbpw_pkg::LEVEL_W-1:0]    m_green_level,
    input  logic [rgbpw_pkg::LEVEL_W-1:0]    m_blue_level,
    input  logic [1:0]                       m_color_class,
    input  logic                             m_range_error,

    output int                               pending,
    output int                               error_count
);
    import rgbpw_pkg::*;

    localparam longint FULL_SCALE  = 255;
    localparam int     CH_RED      = 0;
    localparam int     CH_GREEN    = 1;
    localparam int     CH_BLUE     = 2;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
        color_class_t       color;
        logic               range_err;
    } color_result_t;

    logic [WIDTH_BITS-1:0] cal_low  [NUM_CHAN];
    logic [WIDTH_BITS-1:0] cal_high [NUM_CHAN];
    logic [THR_W-1:0]      threshold;
    color_result_t         expected_colors [$];
    int                    beats_in  = 0;
    int                    beats_out = 0;

    assign pending = beats_in - beats_out;

    // Inverse linear map with truncating division, clamped to the level range.
    function automatic longint width_to_level(input logic [WIDTH_BITS-1:0] raw, lo, hi);
        longint scaled;
        longint span;
        longint lvl;
        if (lo == hi) begin
            return 0;
        end
        scaled = (longint'(raw) - longint'(lo)) * (-FULL_SCALE);
        span   = longint'(hi) - longint'(lo);
        lvl    = scaled / span + FULL_SCALE;
        if (lvl < 0) begin
            lvl = 0;
        end
        if (lvl > FULL_SCALE) begin
            lvl = FULL_SCALE;
        end
        return lvl;
    endfunction

    function automatic color_result_t predict_color(input logic [WIDTH_BITS-1:0] r_w, g_w, b_w);
        longint        r;
        longint        g;
        longint        b;
        longint        t;
        color_result_t res;
        r = width_to_level(r_w, cal_low[CH_RED], cal_high[CH_RED]);
        g = width_to_level(g_w, cal_low[CH_GREEN], cal_high[CH_GREEN]);
        b = width_to_level(b_w, cal_low[CH_BLUE], cal_high[CH_BLUE]);
        t = longint'(threshold);
        if (r < t && g < t && b < t) begin
            res.color = CLASS_NONE;
        end else if (r > g + t && r > b + t) begin
            res.color = CLASS_RED;
        end else if (g > r + t && g > b + t) begin
            res.color = CLASS_GREEN;
        end else if (b > r + t && b > g + t) begin
            res.color = CLASS_BLUE;
        end else begin
            res.color = CLASS_NONE;
        end
        res.red       = LEVEL_W'(r);
        res.green     = LEVEL_W'(g);
        res.blue      = LEVEL_W'(b);
        res.range_err = (cal_low[CH_RED] == cal_high[CH_RED])
                     || (cal_low[CH_GREEN] == cal_high[CH_GREEN])
                     || (cal_low[CH_BLUE] == cal_high[CH_BLUE]);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("result beat %0d, %s: got %0d, expected %0d",
                                      beats_out, name, got, want));
        end
    endtask

    always @(posedge aclk) begin
        color_result_t want;
        if (!aresetn) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
                cal_low[c]  = RST_WIDTH_LOW;
                cal_high[c] = RST_WIDTH_HIGH;
            end
            threshold = RST_THRESHOLD;
            expected_colors.delete();
            beats_in    <= 0;
            beats_out   <= 0;
            error_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RED_LOW:    cal_low[CH_RED]    = cfg_data;
                    CFG_RED_HIGH:   cal_high[CH_RED]   = cfg_data;
                    CFG_GREEN_LOW:  cal_low[CH_GREEN]  = cfg_data;
                    CFG_GREEN_HIGH: cal_high[CH_GREEN] = cfg_data;
                    CFG_BLUE_LOW:   cal_low[CH_BLUE]   = cfg_data;
                    CFG_BLUE_HIGH:  cal_high[CH_BLUE]  = cfg_data;
                    CFG_THRESHOLD:  threshold          = cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_colors.push_back(predict_color(s_red_width, s_green_width,
                                                        s_blue_width));
                beats_in <= beats_in + 1;
            end
            if (m_valid && m_ready) begin
                if (expected_colors.size() == 0) begin
                    report_mismatch("result beat with no input beat outstanding");
                end else begin
                    want = expected_colors.pop_front();
                    check_field("red_level", m_red_level, want.red);
                    check_field("green_level", m_green_level, want.green);
                    check_field("blue_level", m_blue_level, want.blue);
                    check_field("color_class", m_color_class, want.color);
                    check_field("range_error", m_range_error, want.range_err);
                end
                beats_out <= beats_out + 1;
            end
        end
    end

endmodule

FILE: sim/rgb_pulse_width_color_classifier_tb.sv
module rgb_pulse_width_color_classifier_tb;
    import rgbpw_pkg::*;

    localparam int RESET_CYCLES    = 12;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 200;
    // Long receiver hold-off; far more than the pipeline depth, so the block
    // fills up completely and has to drop s_ready.
    localparam int HOLD_CYCLES     = 60;
    // Cycles without any beat on any channel before the run is declared hung.
    localparam int STALL_LIMIT     = 2000;
    localparam int WIDTH_TOP       = (1 << WIDTH_BITS) - 1;

    localparam logic [WIDTH_BITS-1:0] WIDTH_MAX       = {WIDTH_BITS{1'b1}};
    // Index 7 selects no register; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0]  CFG_NO_REGISTER = {CFG_IDX_W{1'b1}};

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [WIDTH_BITS-1:0] cfg_data      = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [WIDTH_BITS-1:0] s_red_width   = '0;
    logic [WIDTH_BITS-1:0] s_green_width = '0;
    logic [WIDTH_BITS-1:0] s_blue_width  = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [LEVEL_W-1:0]    m_red_level;
    logic [LEVEL_W-1:0]    m_green_level;
    logic [LEVEL_W-1:0]    m_blue_level;
    logic [1:0]            m_color_class;
    logic                  m_range_error;

    int pending;
    int error_count;
    int quiet_cycles = 0;

    // Shared between the stimulus and the receiver process. no_idle turns
    // off the random gaps on both sides; hold_req asks the receiver for one
    // long hold-off.
    bit no_idle  = 1'b0;
    bit hold_req = 1'b0;

    // Calibration that the next load_calibration call writes. The threshold
    // word may carry excess bits above the 8 the block keeps.
    logic [WIDTH_BITS-1:0] cal_lo [NUM_CHAN];
    logic [WIDTH_BITS-1:0] cal_hi [NUM_CHAN];
    logic [WIDTH_BITS-1:0] thr_word;

    always #1 aclk = ~aclk;

    rgb_pulse_width_color_classifier uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_red_width   (s_red_width),
        .s_green_width (s_green_width),
        .s_blue_width  (s_blue_width),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_level   (m_red_level),
        .m_green_level (m_green_level),
        .m_blue_level  (m_blue_level),
        .m_color_class (m_color_class),
        .m_range_error (m_range_error)
    );

    // The checker watches all three channels, predicts every result beat and
    // compares it; it hands back the number of beats in flight and the count
    // of mismatches.
    rgbpw_checker color_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_red_width   (s_red_width),
        .s_green_width (s_green_width),
        .s_blue_width  (s_blue_width),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_level   (m_red_level),
        .m_green_level (m_green_level),
        .m_blue_level  (m_blue_level),
        .m_color_class (m_color_class),
        .m_range_error (m_range_error),
        .pending       (pending),
        .error_count   (error_count)
    );

    // Writes one register and returns at the edge that takes it. Valid is
    // left high so back-to-back writes never lower and raise it in one step;
    // load_calibration drops it after its last write.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [WIDTH_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Writes every register from cal_lo, cal_hi and thr_word, followed by a
    // write to the unused index that must not disturb anything.
    task automatic load_calibration();
        write_register(CFG_RED_LOW, cal_lo[0]);
        write_register(CFG_RED_HIGH, cal_hi[0]);
        write_register(CFG_GREEN_LOW, cal_lo[1]);
        write_register(CFG_GREEN_HIGH, cal_hi[1]);
        write_register(CFG_BLUE_LOW, cal_lo[2]);
        write_register(CFG_BLUE_HIGH, cal_hi[2]);
        write_register(CFG_THRESHOLD, thr_word);
        write_register(CFG_NO_REGISTER, WIDTH_BITS'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Sets the same calibration pair on all three channels.
    task automatic set_all_channels(input logic [WIDTH_BITS-1:0] lo, hi);
        for (int c = 0; c < NUM_CHAN; c++) begin
            cal_lo[c] = lo;
            cal_hi[c] = hi;
        end
    endtask

    // Random calibration: mostly narrow spans in either direction, now and
    // then a zero span or an arbitrary pair. Threshold favors small values
    // but hits both ends.
    task automatic draw_calibration();
        int lo;
        int span;
        for (int c = 0; c < NUM_CHAN; c++) begin
            lo   = $urandom_range(0, WIDTH_TOP);
            span = $urandom_range(1, 2000);
            case ($urandom_range(0, 9))
                0: cal_hi[c] = WIDTH_BITS'(lo);
                1: cal_hi[c] = WIDTH_BITS'($urandom);
                default: begin
                    if ($urandom_range(0, 1) != 0) begin
                        cal_hi[c] = WIDTH_BITS'((lo + span > WIDTH_TOP) ? WIDTH_TOP : lo + span);
                    end else begin
                        cal_hi[c] = WIDTH_BITS'((lo < span) ? 0 : lo - span);
                    end
                end
            endcase
            cal_lo[c] = WIDTH_BITS'(lo);
        end
        case ($urandom_range(0, 4))
            0: thr_word = {8'($urandom), 8'd0};
            1: thr_word = {8'($urandom), 8'd255};
            default: thr_word = {8'($urandom), 8'($urandom_range(0, 80))};
        endcase
    endtask

    // Most widths fall in or just around the calibrated span, where levels
    // move and colors compete; the rest are the field extremes, the span
    // ends themselves, or anything at all.
    function automatic logic [WIDTH_BITS-1:0] pick_width(input logic [WIDTH_BITS-1:0] lo, hi);
        int a;
        int b;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        a = (a > 16) ? a - 16 : 0;
        b = (b < WIDTH_TOP - 16) ? b + 16 : WIDTH_TOP;
        case ($urandom_range(0, 9))
            0: return WIDTH_BITS'($urandom);
            1: return ($urandom_range(0, 1) != 0) ? WIDTH_MAX : '0;
            2: return ($urandom_range(0, 1) != 0) ? lo : hi;
            default: return WIDTH_BITS'($urandom_range(b, a));
        endcase
    endfunction

    // Offers one beat after a random gap (none while no_idle is set) and returns
    // at the edge that takes it. Valid stays high if the next beat has no gap.
    task automatic send_widths(input logic [WIDTH_BITS-1:0] r, g, b);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_red_width   <= r;
        s_green_width <= g;
        s_blue_width  <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops offering and waits until every predicted beat has come out. The
    // first edge lets the checker count the beat taken at the current edge.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending > 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats on the reset calibration: 0..1000 on every channel,
        // threshold 50. All bright with no winner, all dim, each color
        // winning, a two-way tie, a level sitting exactly on the threshold, one
        // just above it and two mixed beats.
        send_widths('0, '0, '0);
        send_widths(WIDTH_MAX, WIDTH_MAX, WIDTH_MAX);
        send_widths(16'd0, 16'd1000, 16'd1000);
        send_widths(16'd1000, 16'd0, 16'd1000);
        send_widths(16'd1000, 16'd1000, 16'd0);
        send_widths(16'd0, 16'd0, 16'd1000);
        send_widths(16'd804, 16'd1000, 16'd1000);
        send_widths(16'd800, 16'd1000, 16'd1000);
        send_widths(16'd999, 16'h5555, 16'hAAAA);
        send_widths(16'hAAAA, 16'h5555, 16'd1);
        wait_for_results();

        // Zero span on red: its level is forced to 0 and the error flag rises
        // while the other channels still classify. The threshold word has its
        // excess bits set, which the block must drop.
        set_all_channels(16'd0, 16'd1000);
        cal_lo[0] = 16'd1234;
        cal_hi[0] = 16'd1234;
        thr_word  = 16'hFF32;
        load_calibration();
        send_widths(16'd0, 16'd1000, 16'd1000);
        send_widths(16'd1000, 16'd0, 16'd1000);
        send_widths(16'd1000, 16'd1000, 16'd0);
        wait_for_results();

        // Inverted spans with a zero threshold: the divisor turns negative, levels
        // reach both ends and clamp at 255.
        set_all_channels(16'd1000, 16'd0);
        thr_word = '0;
        load_calibration();
        send_widths('0, '0, '0);
        send_widths(16'd1000, 16'd500, 16'd2000);
        send_widths(WIDTH_MAX, 16'h8000, 16'd1);
        send_widths(16'd400, 16'd1000, 16'd999);

        // Random part. Each phase starts from an idle block, loads a new
        // calibration and streams beats around it. The first two phases use
        // the widest and the fully inverted span with the threshold at its
        // two ends.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_for_results();
            case (phase)
                0: begin
                    set_all_channels('0, WIDTH_MAX);
                    thr_word = 16'h00FF;
                end
                1: begin
                    set_all_channels(WIDTH_MAX, '0);
                    thr_word = 16'hFF00;
                end
                default: draw_calibration();
            endcase
            load_calibration();

            // Some phases run without any gaps. In phase two the receiver
            // also holds off for a long stretch while the sender keeps
            // going back to back, so the pipeline fills and stalls its input.
            no_idle = (phase == 2 || phase == 5) ? 1'b1 : ($urandom_range(0, 3) == 0);
            if (phase == 2) begin
                hold_req = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) begin
                send_widths(pick_width(cal_lo[0], cal_hi[0]),
                            pick_width(cal_lo[1], cal_hi[1]),
                            pick_width(cal_lo[2], cal_hi[2]));
            end
        end

        wait_for_results();
        repeat (NUM_STAGES + 4) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Result side: before each beat it stalls for a random number of cycles
    // (none while no_idle is set), or for one long stretch when the stimulus
    // asks for it, then keeps ready high until a beat is taken.
    initial begin : receiver
        int unsigned stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else if (no_idle) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 3);
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Watchdog: any beat on any channel restarts the count of quiet cycles.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $display("TIMEOUT: no beat accepted for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
